### hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and types for the double-ended queue: command and status
// codes, controller states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DQ_DEPTH  = 16;
  localparam int CMD_W     = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  // command codes; codes above pop back act as peek only
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // end values reported while the queue is empty
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } dq_state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // apply the command to pointers and storage
    logic rd;     // read front and back slots
  } dq_ctl_t;

endpackage

### hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the double-ended queue: steps each transaction through
// capture, execute, read and respond.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dq_ctl_t ctl,
  output logic    out_valid
);

  dq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    out_valid = 1'b0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage, front index and entry count of the double-ended queue,
// with the registered reads of the front and back slots.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = DQ_DEPTH,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_ctl_t                    ctl,
  input  logic        [CMD_W-1:0]    in_cmd,
  input  logic signed [DATA_W-1:0]   in_push_value,
  output logic signed [DATA_W-1:0]   out_front_value,
  output logic signed [DATA_W-1:0]   out_back_value,
  output logic        [CW-1:0]       out_entry_count,
  output logic        [STATUS_W-1:0] out_status
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = IW + 1;

  logic [DATA_W-1:0]   mem [DEPTH];

  logic [CMD_W-1:0]    cmd_r;
  logic [DATA_W-1:0]   val_r;
  logic [IW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]   rd_front_r, rd_back_r;

  logic [IW-1:0]       front_dec, front_inc;
  logic [SW-1:0]       tail_sum, back_sum;
  logic [IW-1:0]       tail_idx, back_idx;
  logic [CW-1:0]       count_m1;
  logic                full, empty;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;

  // ring index arithmetic
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;

  // slot just past the back entry
  assign tail_sum  = SW'(front_r) + SW'(count_r);
  assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);

  // slot of the back entry, meaningful only when not empty
  assign count_m1  = count_r - 1'b1;
  assign back_sum  = SW'(front_r) + SW'(count_m1);
  assign back_idx  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    if (ctl.exec) begin
      unique case (cmd_r) inside
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (cmd_r == CMD_PUSH_FRONT) begin
              wr_addr   = front_dec;
              front_nxt = front_dec;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            if (cmd_r == CMD_POP_FRONT) begin
              front_nxt = front_inc;
            end
          end
        end
        // peek and unused codes leave the queue alone
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      val_r <= in_push_value;
    end
    if (ctl.exec) begin
      status_r <= status_nxt;
    end
  end

  // storage: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_idx];
    end
  end

  assign out_front_value = empty ? EMPTY_VALUE : rd_front_r;
  assign out_back_value  = empty ? EMPTY_VALUE : rd_back_r;
  assign out_entry_count = count_r;
  assign out_status      = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && (cmd_r == CMD_PUSH_FRONT || cmd_r == CMD_PUSH_BACK) && !full
    |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not add an entry");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec && (cmd_r == CMD_POP_FRONT || cmd_r == CMD_POP_BACK) && empty
    |=> empty && front_r == $past(front_r) && status_r == ST_EMPTY)
    else $error("pop on empty queue changed state or missed its flag");

endmodule

### hw/rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit values kept in a ring, with a
// command port for push/pop at either end and a peek-only command.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload
//  -------   ---------        -------
//  input     start / busy     in_cmd, in_push_value
//  result    out_valid        out_front_value, out_back_value,
//                             out_entry_count, out_status
//
// a transaction is taken when start is high and busy is low
// its result shows on the out_ ports for one cycle, in the respond state after
// the execute and read states; a new transaction can be taken
// in the cycle after the result
// so no new transaction is taken until the result has shown, owing to the ring
// write-then-read (write cycle, registered read cycle) and the response cycle
// synchronous active-low reset empties the queue; storage holds no reset
// the receiver cannot stall: out_valid lasts exactly one cycle
//
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter  int DEPTH = DQ_DEPTH,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic        [CMD_W-1:0]    in_cmd,
  input  logic signed [DATA_W-1:0]   in_push_value,
  // result channel
  output logic                       out_valid,
  output logic signed [DATA_W-1:0]   out_front_value,
  output logic signed [DATA_W-1:0]   out_back_value,
  output logic        [CW-1:0]       out_entry_count,
  output logic        [STATUS_W-1:0] out_status
);

  // command group from the sequencer to the datapath
  dq_ctl_t ctl;

  // sequencer: idle, execute, read, respond
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .ctl       (ctl),
    .out_valid (out_valid)
  );

  // ring storage, pointers and end reads
  dq_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

endmodule

### tb/sv/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// Self-checking bench for the double-ended queue. A directed table walks the
// empty, full and wrap-around corners, then random command streams swing the
// queue between empty and full under several input idling patterns. Every
// result is checked against a bench ring model or a hand-written typed row.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DQ_DEPTH + 1);
  // peek-only command and the top of the unused code range, which also peeks
  localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;
  localparam logic [DATA_W-1:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS    = 32'h7fff_ffff;
  localparam int RANDOM_ITEMS  = 528;
  localparam int BIAS_RUN      = 48;    // items between push-heavy and pop-heavy swaps
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES  = 8;     // cycles to watch for stray strobes after the last result
  localparam int REPORT_MAX    = 10;

  // what the queue looks like after one command
  typedef struct {
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [CNT_W-1:0]         count;
    logic [STATUS_W-1:0]      status;
  } deque_view_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    deque_view_t              want;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           in_cmd;
  logic signed [DATA_W-1:0]   in_push_value;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   out_front_value;
  logic signed [DATA_W-1:0]   out_back_value;
  logic [CNT_W-1:0]           out_entry_count;
  logic [STATUS_W-1:0]        out_status;

  // ring model of the queue contents
  logic [DATA_W-1:0]          ring_slots [DQ_DEPTH];
  int unsigned                ring_head;
  int unsigned                ring_held;

  deque_view_t                pending_views [$];   // results still owed by the dut
  stim_row_t                  directed_rows [$];
  deque_view_t                no_view;

  int                         idle_pct;            // chance of holding start low per cycle
  int                         error_count;
  int                         cmds_sent;
  int                         results_seen;
  int                         full_drops;
  int                         empty_pops;
  int                         top_count;
  int                         stall_cycles;

  double_ended_queue_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // ring model: apply one command and return the queue as it then stands
  // --------------------------------------------------------------------------
  function automatic deque_view_t apply_deque_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [DATA_W-1:0] v);
    deque_view_t r;
    r.status = ST_DONE;
    if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) begin
      if (ring_held >= DQ_DEPTH) begin
        r.status = ST_FULL;            // full: value dropped, nothing moves
      end else begin
        if (c == CMD_PUSH_FRONT) begin
          ring_head = (ring_head + DQ_DEPTH - 1) % DQ_DEPTH;
          ring_slots[ring_head] = v;
        end else begin
          ring_slots[(ring_head + ring_held) % DQ_DEPTH] = v;
        end
        ring_held++;
      end
    end else if (c == CMD_POP_FRONT || c == CMD_POP_BACK) begin
      if (ring_held == 0) begin
        r.status = ST_EMPTY;           // empty: pop ignored
      end else begin
        if (c == CMD_POP_FRONT) ring_head = (ring_head + 1) % DQ_DEPTH;
        ring_held--;
      end
    end
    // any other code only peeks
    if (ring_held == 0) begin
      r.front = EMPTY_VALUE;
      r.back  = EMPTY_VALUE;
    end else begin
      r.front = ring_slots[ring_head];
      r.back  = ring_slots[(ring_head + ring_held - 1) % DQ_DEPTH];
    end
    r.count = CNT_W'(ring_held);
    return r;
  endfunction

  task automatic note_error(input string msg);
    if (error_count < REPORT_MAX) $display("%0t ns  ERROR  %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // command driver: optional idle gap, then hold start until busy drops
  // the model is stepped at the accepting edge; typed rows override its result
  // --------------------------------------------------------------------------
  task automatic issue_cmd(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
                           input bit typed, input deque_view_t want);
    deque_view_t modeled;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      // idle cycle: junk on the payload must be ignored
      start         <= 1'b0;
      in_cmd        <= CMD_W'($urandom);
      in_push_value <= $urandom;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= c;
    in_push_value <= v;
    do @(posedge clk); while (busy);
    // transaction taken at this edge
    modeled = apply_deque_cmd(c, v);
    if (typed) begin
      pending_views.push_back(want);
    end else begin
      pending_views.push_back(modeled);
    end
    cmds_sent++;
  endtask

  function automatic stim_row_t make_row(input logic [CMD_W-1:0] c,
                                         input logic [DATA_W-1:0] v);
    stim_row_t row;
    row.cmd   = c;
    row.value = v;
    row.typed = 1'b0;
    row.want  = no_view;
    return row;
  endfunction

  function automatic stim_row_t make_typed(input logic [CMD_W-1:0] c,
                                           input logic [DATA_W-1:0] v,
                                           input logic [DATA_W-1:0] f,
                                           input logic [DATA_W-1:0] b,
                                           input int n,
                                           input logic [STATUS_W-1:0] s);
    stim_row_t row;
    row.cmd          = c;
    row.value        = v;
    row.typed        = 1'b1;
    row.want.front   = f;
    row.want.back    = b;
    row.want.count   = CNT_W'(n);
    row.want.status  = s;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: out_valid is a one-cycle strobe, compared in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    deque_view_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_status == ST_FULL) full_drops++;
      if (out_status == ST_EMPTY) empty_pops++;
      if (out_entry_count > top_count) top_count = out_entry_count;
      if (pending_views.size() == 0) begin
        note_error($sformatf("result with nothing outstanding: front %h back %h count %0d st %0d",
                             out_front_value, out_back_value, out_entry_count, out_status));
      end else begin
        want = pending_views.pop_front();
        if (out_front_value !== want.front || out_back_value !== want.back ||
            out_entry_count !== want.count || out_status !== want.status) begin
          note_error($sformatf({"result %0d: exp front %h back %h count %0d st %0d, ",
                                "got front %h back %h count %0d st %0d"},
                               results_seen, want.front, want.back, want.count, want.status,
                               out_front_value, out_back_value, out_entry_count,
                               out_status));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any accepted command or result resets the stall count
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_views.size());
      $display("tb_double_ended_queue_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int                push_pct;
    int                pick;
    logic [CMD_W-1:0]  c;
    logic [DATA_W-1:0] v;
    int                phase_pct [4];

    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = '0;
    in_push_value = '0;
    idle_pct      = 0;
    error_count   = 0;
    cmds_sent     = 0;
    results_seen  = 0;
    full_drops    = 0;
    empty_pops    = 0;
    top_count     = 0;
    stall_cycles  = 0;
    ring_head     = 0;
    ring_held     = 0;
    no_view       = '{front: '0, back: '0, count: '0, status: ST_DONE};
    // idling per random phase; the receiver phase has nothing to stall
    phase_pct     = '{0, 57, 0, 23};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty corners, push both ends past the ring wrap, full drops
    directed_rows.push_back(make_typed(CMD_PEEK, 32'h1234_5678, EMPTY_VALUE, EMPTY_VALUE,
                                       0, ST_DONE));
    directed_rows.push_back(make_typed(CMD_POP_FRONT, '0, EMPTY_VALUE, EMPTY_VALUE,
                                       0, ST_EMPTY));
    directed_rows.push_back(make_typed(CMD_POP_BACK, '1, EMPTY_VALUE, EMPTY_VALUE,
                                       0, ST_EMPTY));
    // push front from an empty ring wraps the head below slot zero
    directed_rows.push_back(make_typed(CMD_PUSH_FRONT, MOST_NEG, MOST_NEG, MOST_NEG,
                                       1, ST_DONE));
    directed_rows.push_back(make_typed(CMD_PUSH_BACK, MOST_POS, MOST_NEG, MOST_POS,
                                       2, ST_DONE));
    for (int k = 0; k < DQ_DEPTH - 2; k++) begin
      v = (k == DQ_DEPTH - 3) ? '0 : (32'h5a5a_5a00 | k);
      directed_rows.push_back(make_row(CMD_PUSH_BACK, v));
    end
    // full now: both pushes dropped, back is the last value written (zero)
    directed_rows.push_back(make_typed(CMD_PUSH_FRONT, '1, MOST_NEG, '0, DQ_DEPTH, ST_FULL));
    directed_rows.push_back(make_typed(CMD_PUSH_BACK, '1, MOST_NEG, '0, DQ_DEPTH, ST_FULL));
    directed_rows.push_back(make_row(CMD_POP_FRONT, '0));
    directed_rows.push_back(make_row(CMD_POP_BACK, '0));
    directed_rows.push_back(make_row(CMD_SPARE_HI, '1));

    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].want);

    // random streams: runs alternate push-heavy and pop-heavy so the queue
    // keeps crossing between empty and full
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = phase_pct[(n * 4) / RANDOM_ITEMS];
      push_pct = ((n / BIAS_RUN) % 2 == 0) ? 62 : 25;
      pick     = $urandom_range(99);
      if (pick < 10) begin
        c = CMD_W'($urandom_range(CMD_PEEK, CMD_SPARE_HI));
      end else if (pick < 10 + push_pct) begin
        c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      case ($urandom_range(9))
        0:       v = MOST_NEG;
        1:       v = MOST_POS;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      issue_cmd(c, v, 1'b0, no_view);
    end

    start <= 1'b0;
    // wait out every outstanding result, then give stray strobes time to show
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands, %0d results checked, peak depth %0d of %0d",
             cmds_sent, results_seen, top_count, DQ_DEPTH);
    $display("%0d pushes dropped on full, %0d pops on empty, %0d mismatches",
             full_drops, empty_pops, error_count);
    if (error_count == 0) begin
      $display("tb_double_ended_queue_top: clean");
    end else begin
      $display("tb_double_ended_queue_top: errors");
    end
    $finish;
  end

endmodule
